[sv/bms_pkg.sv]
// Shared constants, width functions and handshake structs of the block statistics unit.
package bms_pkg;

	localparam int MAX_BLOCK_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int LEN_W           = 13;
	localparam int TIME_W          = 32;
	localparam int Q4_W            = 14;
	localparam int DATA_W          = 32;
	localparam int ADDR_W          = 3;
	localparam int FRAC_BITS       = 4;
	localparam int VAR_FRAC        = 8;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST = 13'd6;
	localparam logic [Q4_W-1:0]  Q4_MAX           = 14'h3fff;
	localparam logic             REG_BLOCK_LENGTH = 1'b0;

	typedef struct packed {
		logic full;
		logic empty;
	} bms_q_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bms_div_stat_t;

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int cnt_w(input int mb);
		return $clog2(mb + 1);
	endfunction

	function automatic int sum_w(input int sb, input int mb);
		return sb + $clog2(mb);
	endfunction

	function automatic int sq_w(input int sb, input int mb);
		return 2 * sb + $clog2(mb);
	endfunction

	function automatic int tsum_w(input int mb);
		return TIME_W + $clog2(mb);
	endfunction

	function automatic int dif_w(input int sb, input int mb);
		return 2 * sb + 2 * $clog2(mb);
	endfunction

	function automatic int den_w(input int mb);
		return 2 * cnt_w(mb);
	endfunction

	function automatic int var_w(input int sb);
		return 2 * sb + VAR_FRAC;
	endfunction

	function automatic int num_w(input int sb, input int mb);
		return max2(dif_w(sb, mb) + VAR_FRAC, max2(tsum_w(mb), sum_w(sb, mb) + FRAC_BITS));
	endfunction

	function automatic int quo_w(input int sb, input int mb);
		return max2(TIME_W, max2(var_w(sb), sum_w(sb, mb) + FRAC_BITS));
	endfunction

	function automatic int step_w(input int sb, input int mb);
		return $clog2(num_w(sb, mb) + 1);
	endfunction

	function automatic int job_w(input int sb, input int mb);
		return cnt_w(mb) + sum_w(sb, mb) + sq_w(sb, mb) + tsum_w(mb);
	endfunction

endpackage

[sv/bms_front.sv]
// Front end: takes requests, drops the first one, accumulates sums and hands off full blocks.
module bms_front #(
	parameter int MAX_BLOCK   = bms_pkg::MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = bms_pkg::SAMPLE_BITS_DEF,
	localparam int CW   = bms_pkg::cnt_w(MAX_BLOCK),
	localparam int SUMW = bms_pkg::sum_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int SQW  = bms_pkg::sq_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int TW   = bms_pkg::tsum_w(MAX_BLOCK),
	localparam int JW   = bms_pkg::job_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int KW   = bms_pkg::max2(CW, bms_pkg::LEN_W)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic [SAMPLE_BITS-1:0]         sample,
	input  logic [bms_pkg::TIME_W-1:0]     timestamp,
	input  logic [bms_pkg::LEN_W-1:0]      block_length,
	input  bms_pkg::bms_q_stat_t           q_stat,
	output logic                           push,
	output logic [JW-1:0]                  push_data
);

	logic                     skip_q;
	logic [CW-1:0]            cnt_q;
	logic [SUMW-1:0]          sum_q;
	logic [SQW-1:0]           sq_q;
	logic [TW-1:0]            tsum_q;
	logic                     accept;
	logic                     block_end;
	logic [CW-1:0]            cnt_nx;
	logic [SUMW-1:0]          sum_nx;
	logic [SQW-1:0]           sq_nx;
	logic [TW-1:0]            tsum_nx;
	logic [2*SAMPLE_BITS-1:0] sq_prod;

	assign sample_stall = q_stat.full;
	assign accept       = sample_valid && !sample_stall;

	assign sq_prod = (2*SAMPLE_BITS)'(sample) * (2*SAMPLE_BITS)'(sample);
	assign cnt_nx  = cnt_q + CW'(1);
	assign sum_nx  = sum_q + SUMW'(sample);
	assign sq_nx   = sq_q + SQW'(sq_prod);
	assign tsum_nx = tsum_q + TW'(timestamp);

	// effective length is block_length clamped to [2, MAX_BLOCK]
	assign block_end = (cnt_nx >= CW'(2)) &&
		((KW'(cnt_nx) >= KW'(block_length)) || (cnt_nx >= CW'(MAX_BLOCK)));

	assign push      = accept && !skip_q && block_end;
	assign push_data = {cnt_nx, sum_nx, sq_nx, tsum_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b1;
			cnt_q  <= '0;
			sum_q  <= '0;
			sq_q   <= '0;
			tsum_q <= '0;
		end else if (accept) begin
			if (skip_q) begin
				skip_q <= 1'b0;
			end else if (block_end) begin
				cnt_q  <= '0;
				sum_q  <= '0;
				sq_q   <= '0;
				tsum_q <= '0;
			end else begin
				cnt_q  <= cnt_nx;
				sum_q  <= sum_nx;
				sq_q   <= sq_nx;
				tsum_q <= tsum_nx;
			end
		end
	end

	a_clear_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (sum_q == '0 && cnt_q == '0 && tsum_q == '0))
		else $error("sums not cleared after block hand-off");

endmodule

[sv/bms_queue.sv]
// Short job queue between front end and back end.
module bms_queue #(
	parameter int MAX_BLOCK   = bms_pkg::MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = bms_pkg::SAMPLE_BITS_DEF,
	localparam int JW  = bms_pkg::job_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int QPW = $clog2(bms_pkg::QUEUE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [JW-1:0]        push_data,
	input  logic                 pop,
	output logic [JW-1:0]        pop_data,
	output bms_pkg::bms_q_stat_t stat
);

	logic [JW-1:0]  mem [bms_pkg::QUEUE_DEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QPW:0]   cnt_q;

	assign stat.full  = (cnt_q == (QPW+1)'(bms_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPW+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("job queue underflow");

endmodule

[sv/bms_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all end-of-block divisions.
module bms_div #(
	parameter int MAX_BLOCK   = bms_pkg::MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = bms_pkg::SAMPLE_BITS_DEF,
	localparam int NW  = bms_pkg::num_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int DNW = bms_pkg::den_w(MAX_BLOCK),
	localparam int QW  = bms_pkg::quo_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int SW  = bms_pkg::step_w(SAMPLE_BITS, MAX_BLOCK)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NW-1:0]          num,
	input  logic [DNW-1:0]         den,
	input  logic [SW-1:0]          steps,
	output bms_pkg::bms_div_stat_t stat,
	output logic [QW-1:0]          quo
);

	logic [NW-1:0]  num_q;
	logic [DNW-1:0] den_q;
	logic [DNW-1:0] rem_q;
	logic [QW-1:0]  quo_q;
	logic [SW-1:0]  step_q;
	logic           busy_q;
	logic           done_q;
	logic [DNW:0]   trial;
	logic [DNW:0]   diff;
	logic           ge;

	// numerator arrives left-aligned; its top bit enters the remainder each step
	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= steps;
			end else if (busy_q) begin
				step_q <= step_q - SW'(1);
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[DNW-1:0] : trial[DNW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

endmodule

[sv/bms_back.sv]
// Back end: pops block jobs, runs multiply, divide and square-root steps, holds the result.
module bms_back #(
	parameter int MAX_BLOCK   = bms_pkg::MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = bms_pkg::SAMPLE_BITS_DEF,
	localparam int CW   = bms_pkg::cnt_w(MAX_BLOCK),
	localparam int SUMW = bms_pkg::sum_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int SQW  = bms_pkg::sq_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int TW   = bms_pkg::tsum_w(MAX_BLOCK),
	localparam int DIFW = bms_pkg::dif_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int DENW = bms_pkg::den_w(MAX_BLOCK),
	localparam int NW   = bms_pkg::num_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int QW   = bms_pkg::quo_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int VW   = bms_pkg::var_w(SAMPLE_BITS),
	localparam int DSW  = bms_pkg::step_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int JW   = bms_pkg::job_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int BCW  = $clog2(bms_pkg::max2(SUMW, VW / 2) + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bms_pkg::bms_q_stat_t          q_stat,
	output logic                          pop,
	input  logic [JW-1:0]                 pop_data,
	output logic                          div_start,
	output logic [NW-1:0]                 div_num,
	output logic [DENW-1:0]               div_den,
	output logic [DSW-1:0]                div_steps,
	input  bms_pkg::bms_div_stat_t        div_stat,
	input  logic [QW-1:0]                 div_quo,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [bms_pkg::Q4_W-1:0]      mean_q4,
	output logic [bms_pkg::Q4_W-1:0]      stddev_q4,
	output logic [bms_pkg::TIME_W-1:0]    mean_time
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MULA = 8'b0000_0010,
		ST_MULB = 8'b0000_0100,
		ST_DIVV = 8'b0000_1000,
		ST_SQRT = 8'b0001_0000,
		ST_DIVM = 8'b0010_0000,
		ST_DIVT = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   j_n;
	logic [SUMW-1:0]                 j_sum;
	logic [SQW-1:0]                  j_sq;
	logic [TW-1:0]                   j_ts;
	logic [CW-1:0]                   n_q;
	logic [SUMW-1:0]                 sum_q;
	logic [TW-1:0]                   tsum_q;
	logic [DIFW-1:0]                 acc_q;
	logic [DENW-1:0]                 macc_q;
	logic [DIFW-1:0]                 mcand_q;
	logic [DENW-1:0]                 nm1_q;
	logic [SUMW-1:0]                 mplier_q;
	logic [BCW-1:0]                  stp_q;
	logic [VW-1:0]                   x_q;
	logic [VW-1:0]                   res_q;
	logic [VW-1:0]                   bit_q;
	logic [bms_pkg::Q4_W-1:0]        mean_q;
	logic [bms_pkg::Q4_W-1:0]        sd_q;
	logic [bms_pkg::TIME_W-1:0]      mt_q;
	logic                            result_valid_q;
	logic [bms_pkg::Q4_W-1:0]        mean_q4_q;
	logic [bms_pkg::Q4_W-1:0]        stddev_q4_q;
	logic [bms_pkg::TIME_W-1:0]      mean_time_q;
	logic                            last;
	logic                            out_free;
	logic [DIFW-1:0]                 acc_end;
	logic [VW:0]                     sq_trial;
	logic                            sq_ge;
	logic [VW-1:0]                   res_nx;
	logic [VW-1:0]                   x_nx;
	logic [bms_pkg::Q4_W-1:0]        sd_sat;
	logic [bms_pkg::Q4_W-1:0]        mean_sat;

	assign {j_n, j_sum, j_sq, j_ts} = pop_data;

	assign last     = (stp_q == BCW'(1));
	assign out_free = !result_valid_q || !result_stall;
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;

	// d = n*sumsq - sum^2, built one subtraction step at a time
	assign acc_end = mplier_q[0] ? acc_q - mcand_q : acc_q;

	assign sq_trial = {1'b0, res_q} + {1'b0, bit_q};
	assign sq_ge    = ({1'b0, x_q} >= sq_trial);
	assign x_nx     = sq_ge ? x_q - sq_trial[VW-1:0] : x_q;
	assign res_nx   = sq_ge ? (res_q >> 1) + bit_q : res_q >> 1;
	assign sd_sat   = (res_nx > VW'(bms_pkg::Q4_MAX)) ? bms_pkg::Q4_MAX
		: res_nx[bms_pkg::Q4_W-1:0];
	assign mean_sat = (div_quo > QW'(bms_pkg::Q4_MAX)) ? bms_pkg::Q4_MAX
		: div_quo[bms_pkg::Q4_W-1:0];

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = DENW'(n_q);
		div_steps = '0;
		if (state_q == ST_MULB && last) begin
			div_start = 1'b1;
			div_num   = NW'({acc_end, {bms_pkg::VAR_FRAC{1'b0}}})
				<< (NW - DIFW - bms_pkg::VAR_FRAC);
			div_den   = macc_q;
			div_steps = DSW'(DIFW + bms_pkg::VAR_FRAC);
		end else if (state_q == ST_SQRT && last) begin
			div_start = 1'b1;
			div_num   = NW'({sum_q, {bms_pkg::FRAC_BITS{1'b0}}})
				<< (NW - SUMW - bms_pkg::FRAC_BITS);
			div_steps = DSW'(SUMW + bms_pkg::FRAC_BITS);
		end else if (state_q == ST_DIVM && div_stat.done) begin
			div_start = 1'b1;
			div_num   = NW'(tsum_q) << (NW - TW);
			div_steps = DSW'(TW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_MULA;
					end
				end
				ST_MULA: begin
					if (last) begin
						state_q <= ST_MULB;
					end
				end
				ST_MULB: begin
					if (last) begin
						state_q <= ST_DIVV;
					end
				end
				ST_DIVV: begin
					if (div_stat.done) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (last) begin
						state_q <= ST_DIVM;
					end
				end
				ST_DIVM: begin
					if (div_stat.done) begin
						state_q <= ST_DIVT;
					end
				end
				ST_DIVT: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					n_q      <= j_n;
					sum_q    <= j_sum;
					tsum_q   <= j_ts;
					acc_q    <= '0;
					macc_q   <= '0;
					mcand_q  <= DIFW'(j_sq);
					nm1_q    <= DENW'(j_n - CW'(1));
					mplier_q <= SUMW'(j_n);
					stp_q    <= BCW'(CW);
				end
			end
			ST_MULA: begin
				if (mplier_q[0]) begin
					acc_q  <= acc_q + mcand_q;
					macc_q <= macc_q + nm1_q;
				end
				nm1_q <= nm1_q << 1;
				if (last) begin
					mcand_q  <= DIFW'(sum_q);
					mplier_q <= sum_q;
					stp_q    <= BCW'(SUMW);
				end else begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					stp_q    <= stp_q - BCW'(1);
				end
			end
			ST_MULB: begin
				acc_q    <= acc_end;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				stp_q    <= stp_q - BCW'(1);
			end
			ST_DIVV: begin
				if (div_stat.done) begin
					x_q   <= div_quo[VW-1:0];
					res_q <= '0;
					bit_q <= VW'(1) << (VW - 2);
					stp_q <= BCW'(VW / 2);
				end
			end
			ST_SQRT: begin
				x_q   <= x_nx;
				res_q <= res_nx;
				bit_q <= bit_q >> 2;
				stp_q <= stp_q - BCW'(1);
				if (last) begin
					sd_q <= sd_sat;
				end
			end
			ST_DIVM: begin
				if (div_stat.done) begin
					mean_q <= mean_sat;
				end
			end
			ST_DIVT: begin
				if (div_stat.done) begin
					mt_q <= div_quo[bms_pkg::TIME_W-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					mean_q4_q   <= mean_q;
					stddev_q4_q <= sd_q;
					mean_time_q <= mt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign mean_q4      = mean_q4_q;
	assign stddev_q4    = stddev_q4_q;
	assign mean_time    = mean_time_q;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

endmodule

[sv/block_mean_stddev.sv]
// Top level of the block mean and standard deviation unit: register port and unit wiring.
// Requests (sample, timestamp) are taken one per cycle while the two-entry job queue has
// room; the first request after reset is dropped. Each completed block is then worked
// off by the back end with the shift-add multiplier, the one-bit-per-cycle divider used
// three times and the two-bit-per-cycle square root. Up to two finished blocks wait in
// the queue and one result in the output register. block_length at byte address 0 is
// clamped to [2, MAX_BLOCK]; write it only while the unit is idle. No clearing pass
// after reset.
module block_mean_stddev #(
	parameter int MAX_BLOCK   = bms_pkg::MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = bms_pkg::SAMPLE_BITS_DEF,
	localparam int DENW = bms_pkg::den_w(MAX_BLOCK),
	localparam int NW   = bms_pkg::num_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int QW   = bms_pkg::quo_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int DSW  = bms_pkg::step_w(SAMPLE_BITS, MAX_BLOCK),
	localparam int JW   = bms_pkg::job_w(SAMPLE_BITS, MAX_BLOCK)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bms_pkg::ADDR_W-1:0]    paddr,
	input  logic [bms_pkg::DATA_W-1:0]    pwdata,
	output logic [bms_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic [bms_pkg::TIME_W-1:0]    timestamp,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [bms_pkg::Q4_W-1:0]      mean_q4,
	output logic [bms_pkg::Q4_W-1:0]      stddev_q4,
	output logic [bms_pkg::TIME_W-1:0]    mean_time
);

	logic [bms_pkg::LEN_W-1:0] block_length_q;
	logic                      reg_sel;
	logic                      push;
	logic [JW-1:0]             push_data;
	logic                      pop;
	logic [JW-1:0]             pop_data;
	bms_pkg::bms_q_stat_t      q_stat;
	logic                      div_start;
	logic [NW-1:0]             div_num;
	logic [DENW-1:0]           div_den;
	logic [DSW-1:0]            div_steps;
	bms_pkg::bms_div_stat_t    div_stat;
	logic [QW-1:0]             div_quo;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[bms_pkg::ADDR_W-1] == bms_pkg::REG_BLOCK_LENGTH);
	assign prdata  = reg_sel ? bms_pkg::DATA_W'(block_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= bms_pkg::BLOCK_LENGTH_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			block_length_q <= pwdata[bms_pkg::LEN_W-1:0];
		end
	end

	bms_front #(
		.MAX_BLOCK  (MAX_BLOCK),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.timestamp   (timestamp),
		.block_length(block_length_q),
		.q_stat      (q_stat),
		.push        (push),
		.push_data   (push_data)
	);

	bms_queue #(
		.MAX_BLOCK  (MAX_BLOCK),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.stat     (q_stat)
	);

	bms_div #(
		.MAX_BLOCK  (MAX_BLOCK),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.steps (div_steps),
		.stat  (div_stat),
		.quo   (div_quo)
	);

	bms_back #(
		.MAX_BLOCK  (MAX_BLOCK),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.pop         (pop),
		.pop_data    (pop_data),
		.div_start   (div_start),
		.div_num     (div_num),
		.div_den     (div_den),
		.div_steps   (div_steps),
		.div_stat    (div_stat),
		.div_quo     (div_quo),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.mean_q4     (mean_q4),
		.stddev_q4   (stddev_q4),
		.mean_time   (mean_time)
	);

endmodule
